// ----- sv/csvfs_pkg.sv -----
package csvfs_pkg;

   // Sizing of the line and field bookkeeping.
   localparam int MAX_FIELDS   = 32;
   localparam int LINE_LEN_MAX = 4096;
   localparam int NA_MAX_BYTES = 8;
   localparam int COUNT_SAT    = 63;
   localparam int QCOL_N       = 32;

   localparam int POS_W      = 13;
   localparam int COL_W      = 6;
   localparam int NA_LEN_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [POS_W-1:0]    LINE_POS_LIMIT = POS_W'(LINE_LEN_MAX);
   localparam logic [COL_W:0]      MAX_FIELDS_C   = (COL_W + 1)'(MAX_FIELDS);
   localparam logic [COL_W-1:0]    COUNT_SAT_C    = COL_W'(COUNT_SAT);
   localparam logic [COL_W-1:0]    QCOL_C         = COL_W'(QCOL_N);
   localparam logic [NA_LEN_W-1:0] NA_MAX_C       = NA_LEN_W'(NA_MAX_BYTES);

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // Error codes carried in a result.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_DOS_CR    = 3'd1;
   localparam logic [2:0] ERR_UNCLOSED  = 3'd2;
   localparam logic [2:0] ERR_COUNT     = 3'd3;
   localparam logic [2:0] ERR_BAD_QUOTE = 3'd4;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_SEP,
      CSR_QUOTE_BYTE,
      CSR_EOL_MODE,
      CSR_EXPECTED_FIELDS,
      CSR_NA_LENGTH,
      CSR_NA_BYTES,
      CSR_QUOTED_COLUMNS
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_PLAIN,
      MODE_QUOTED,
      MODE_SKIP
   } scan_mode_type;

   typedef enum logic [1:0] {
      PH_STREAM,
      PH_DRAIN,
      PH_CLOSE,
      PH_STATUS
   } line_phase_type;

   typedef struct packed {
      logic             kind;
      logic [COL_W-1:0] column;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] stop;
      logic             missing;
      logic             valid;
      logic [2:0]       err;
      logic             last;
   } rsp_item_type;

endpackage

// ----- sv/csvfs_rsp_queue.sv -----
module csvfs_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  csvfs_pkg::rsp_item_type push_item,
   output logic                    has_room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output csvfs_pkg::rsp_item_type out_item
);
   import csvfs_pkg::*;

   // Two result slots used as a small ring.
   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = out_valid & out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign out_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/csv_record_field_splitter_unit.sv -----
// CSV record field splitter.
// A record line enters on the req channel one byte per transfer, with
// req_line_last set on its final byte. The csr channel writes the separator,
// quote, end of line mode, expected field count, missing value string and
// quoted column mask; it is always ready, and the user must write it between
// lines; the block does not enforce this. Each field below MAX_FIELDS gives
// one result on the rsp channel with its byte range; every line ends with one
// status result (rsp_result_last set) with the field count and error code.
// Throughput is one byte per cycle unless a line closes or the queue is full.
// Two bytes are always held back so the end of line can be stripped, so a field
// result enters the queue two byte transfers after the byte that closes it.
// After the transfer of a final byte, req_ready stays low while the
// single byte scan step feeds the up to three held bytes, one per cycle while
// the queue has room; then an open field is closed and the status is issued.
// Results go into a two entry queue, so a byte is still taken while one
// result waits; when the receiver stalls and the queue holds two results,
// req_ready drops until a result transfer frees a slot.
// Reset restores the register defaults, clears the line state and empties
// the result queue.
module csv_record_field_splitter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_line_byte,
   input  logic                                 req_line_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_item_kind,
   output logic [csvfs_pkg::COL_W-1:0]          rsp_column_index,
   output logic [csvfs_pkg::POS_W-1:0]          rsp_field_start,
   output logic [csvfs_pkg::POS_W-1:0]          rsp_field_end,
   output logic                                 rsp_field_missing,
   output logic                                 rsp_line_valid,
   output logic [2:0]                           rsp_error_code,
   output logic                                 rsp_result_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [csvfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csvfs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import csvfs_pkg::*;

   // Configuration registers.
   logic [7:0]          field_sep_ff;
   logic [7:0]          quote_byte_ff;
   logic                eol_mode_ff;
   logic [COL_W-1:0]    expected_fields_ff;
   logic [NA_LEN_W-1:0] na_length_ff;
   logic [63:0]         na_bytes_ff;
   logic [QCOL_N-1:0]   quoted_columns_ff;

   // Line state.
   line_phase_type      phase_ff, phase_in;
   scan_mode_type       mode_ff, mode_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]          hold_ff [3];
   logic [7:0]          hold_in [3];
   logic [1:0]          hold_cnt_ff, hold_cnt_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [POS_W-1:0]    fstart_ff, fstart_in;
   logic                na_ok_ff, na_ok_in;
   logic [NA_LEN_W-1:0] na_len_ff, na_len_in;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          last_ff, last_in;
   logic                err5_ff, err5_in;
   logic                err4_ff, err4_in;
   logic                eol_bad_ff, eol_bad_in;
   logic                unclosed_ff, unclosed_in;

   logic                room;
   logic                req_fire;
   logic                push_valid;
   rsp_item_type        push_item;
   rsp_item_type        out_item;
   logic [NA_LEN_W-1:0] na_eff;

   // Byte scan step on the oldest held byte.
   logic [7:0]          fb;
   logic                fd_over;
   logic [POS_W-1:0]    fd_p;
   logic [POS_W-1:0]    fd_after;
   logic [POS_W-1:0]    fd_pos_next;
   logic                fd_take;
   logic                fd_emit;
   logic [POS_W-1:0]    fd_end;
   scan_mode_type       fd_mode_next;
   logic [POS_W-1:0]    bs_start;
   logic                bs_ok;
   logic [NA_LEN_W-1:0] bs_len;
   logic [7:0]          bs_first;
   logic [7:0]          bs_last;
   logic                tk_ok;
   logic [NA_LEN_W-1:0] tk_len;
   logic [7:0]          tk_first;
   logic                nf_ok;
   logic [NA_LEN_W-1:0] nf_len;
   logic [7:0]          nf_first;
   logic [7:0]          nf_last;

   // Field result built from either the scan step or the line close.
   logic                em_close;
   logic [POS_W-1:0]    em_start;
   logic [POS_W-1:0]    em_end;
   logic                em_ok;
   logic [NA_LEN_W-1:0] em_len;
   logic [7:0]          em_first;
   logic [7:0]          em_last;
   logic                em_in_range;
   logic                em_missing;
   logic                em_quoted_col;
   logic                em_wrap_ok;
   logic                em_bad;
   logic [COL_W-1:0]    col_next;
   rsp_item_type        field_item;

   // Line status.
   logic                st_mismatch;
   logic [2:0]          st_err;
   rsp_item_type        status_item;

   // Final byte handling.
   logic [1:0]          lt_n;
   logic [1:0]          lt_keep;
   logic [7:0]          lt_prev;
   logic                lt_eol_bad;
   logic                lt_too_long;

   assign csr_ready = 1'b1;
   assign req_ready = (phase_ff == PH_STREAM) & room;
   assign req_fire  = req_valid & req_ready;
   assign na_eff    = (na_length_ff > NA_MAX_C) ? NA_MAX_C : na_length_ff;

   // One scan step: field splitting and the per-byte missing value match.
   always_comb begin
      fb          = hold_ff[0];
      fd_over     = (pos_ff >= LINE_POS_LIMIT);
      fd_p        = fd_over ? LINE_POS_LIMIT : pos_ff;
      fd_after    = fd_over ? LINE_POS_LIMIT : pos_ff + POS_W'(1);
      fd_pos_next = fd_over ? pos_ff : pos_ff + POS_W'(1);

      // A field that begins at this byte starts from a fresh match state.
      if (mode_ff == MODE_START) begin
         bs_start = fd_p;
         bs_ok    = 1'b1;
         bs_len   = '0;
         bs_first = 8'd0;
         bs_last  = 8'd0;
      end else begin
         bs_start = fstart_ff;
         bs_ok    = na_ok_ff;
         bs_len   = na_len_ff;
         bs_first = first_ff;
         bs_last  = last_ff;
      end

      fd_take      = 1'b0;
      fd_emit      = 1'b0;
      fd_end       = fd_p;
      fd_mode_next = mode_ff;
      unique case (mode_ff)
         MODE_START: begin
            if ((quote_byte_ff != 8'd0) && (fb == quote_byte_ff)) begin
               fd_take      = 1'b1;
               fd_mode_next = MODE_QUOTED;
            end else if (fb == field_sep_ff) begin
               fd_emit = 1'b1;
            end else begin
               fd_take      = 1'b1;
               fd_mode_next = MODE_PLAIN;
            end
         end
         MODE_PLAIN: begin
            if (fb == field_sep_ff) begin
               fd_emit      = 1'b1;
               fd_mode_next = MODE_START;
            end else begin
               fd_take = 1'b1;
            end
         end
         MODE_QUOTED: begin
            fd_take = 1'b1;
            if (fb == quote_byte_ff) begin
               fd_emit      = 1'b1;
               fd_end       = fd_after;
               fd_mode_next = MODE_SKIP;
            end
         end
         MODE_SKIP: begin
            fd_mode_next = MODE_START;
         end
         default: begin
            fd_mode_next = MODE_START;
         end
      endcase

      // Taking a byte into the field: remember first and last byte, and
      // compare it with the missing value byte at the same place.
      tk_first = (bs_len == '0) ? fb : bs_first;
      tk_ok    = bs_ok & (bs_len < na_eff) &
                 (fb == na_bytes_ff[{bs_len[2:0], 3'b000} +: 8]);
      tk_len   = (bs_len <= NA_MAX_C) ? bs_len + NA_LEN_W'(1) : bs_len;

      nf_ok    = fd_take ? tk_ok    : bs_ok;
      nf_len   = fd_take ? tk_len   : bs_len;
      nf_first = fd_take ? tk_first : bs_first;
      nf_last  = fd_take ? fb       : bs_last;
   end

   // Field result. At line close the open field is given as it stands.
   always_comb begin
      em_close = (phase_ff == PH_CLOSE);
      if (em_close) begin
         em_start = fstart_ff;
         em_end   = pos_ff;
         em_ok    = na_ok_ff;
         em_len   = na_len_ff;
         em_first = first_ff;
         em_last  = last_ff;
      end else begin
         em_start = bs_start;
         em_end   = fd_end;
         em_ok    = nf_ok;
         em_len   = nf_len;
         em_first = nf_first;
         em_last  = nf_last;
      end

      em_in_range   = ({1'b0, col_ff} < MAX_FIELDS_C) && (col_ff < COUNT_SAT_C);
      em_missing    = em_ok && (em_len == na_eff);
      em_quoted_col = !em_missing && (col_ff < QCOL_C) && quoted_columns_ff[col_ff[4:0]];
      em_wrap_ok    = (em_len >= NA_LEN_W'(2)) && (em_first == quote_byte_ff) &&
                      (em_last == quote_byte_ff) &&
                      ({1'b0, em_end} >= ({1'b0, em_start} + (POS_W + 1)'(2)));
      em_bad        = em_quoted_col && !em_wrap_ok;
      col_next      = (col_ff == COUNT_SAT_C) ? col_ff : col_ff + COL_W'(1);

      field_item.kind    = 1'b0;
      field_item.column  = col_ff;
      field_item.start   = (em_quoted_col && em_wrap_ok) ? em_start + POS_W'(1) : em_start;
      field_item.stop    = (em_quoted_col && em_wrap_ok) ? em_end - POS_W'(1) : em_end;
      field_item.missing = em_missing;
      field_item.valid   = 1'b0;
      field_item.err     = em_bad ? ERR_BAD_QUOTE : ERR_NONE;
      field_item.last    = 1'b0;
   end

   // Line status, with too long ahead of a bad DOS end, an unclosed quote,
   // a count mismatch and a badly quoted field.
   always_comb begin
      st_mismatch = (col_ff != expected_fields_ff) || ({1'b0, col_ff} > MAX_FIELDS_C) ||
                    (col_ff >= COUNT_SAT_C);
      priority if (err5_ff) begin
         st_err = ERR_TOO_LONG;
      end else if (eol_bad_ff) begin
         st_err = ERR_DOS_CR;
      end else if (unclosed_ff) begin
         st_err = ERR_UNCLOSED;
      end else if (st_mismatch) begin
         st_err = ERR_COUNT;
      end else if (err4_ff) begin
         st_err = ERR_BAD_QUOTE;
      end else begin
         st_err = ERR_NONE;
      end

      status_item.kind    = 1'b1;
      status_item.column  = col_ff;
      status_item.start   = '0;
      status_item.stop    = pos_ff;
      status_item.missing = 1'b0;
      status_item.valid   = (st_err == ERR_NONE);
      status_item.err     = st_err;
      status_item.last    = 1'b1;
   end

   // End of line on the final byte: which of the held bytes and the final
   // byte are still scanned once the newline, and in DOS mode the carriage
   // return before it, are dropped.
   always_comb begin
      lt_n        = hold_cnt_ff + 2'd1;
      lt_prev     = (hold_cnt_ff == 2'd1) ? hold_ff[0] : hold_ff[1];
      lt_eol_bad  = 1'b0;
      lt_keep     = lt_n;
      lt_too_long = (({1'b0, pos_ff} + (POS_W + 1)'(lt_n)) > {1'b0, LINE_POS_LIMIT});
      if (req_line_byte == CHAR_LF) begin
         if (!eol_mode_ff) begin
            lt_keep = lt_n - 2'd1;
         end else if ((lt_n >= 2'd2) && (lt_prev == CHAR_CR)) begin
            lt_keep = lt_n - 2'd2;
         end else begin
            lt_eol_bad = 1'b1;
         end
      end
   end

   // Sequencing of the line.
   always_comb begin
      logic feed_en;
      logic close_emit;
      logic status_push;

      feed_en     = 1'b0;
      close_emit  = 1'b0;
      status_push = 1'b0;

      phase_in    = phase_ff;
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      hold_in[0]  = hold_ff[0];
      hold_in[1]  = hold_ff[1];
      hold_in[2]  = hold_ff[2];
      hold_cnt_in = hold_cnt_ff;
      col_in      = col_ff;
      fstart_in   = fstart_ff;
      na_ok_in    = na_ok_ff;
      na_len_in   = na_len_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      err5_in     = err5_ff;
      err4_in     = err4_ff;
      eol_bad_in  = eol_bad_ff;
      unclosed_in = unclosed_ff;
      push_valid  = 1'b0;
      push_item   = field_item;

      unique case (phase_ff)
         PH_STREAM: begin
            if (req_fire) begin
               if (!req_line_last) begin
                  if (hold_cnt_ff == 2'd2) begin
                     feed_en    = 1'b1;
                     hold_in[0] = hold_ff[1];
                     hold_in[1] = req_line_byte;
                  end else begin
                     if (hold_cnt_ff == 2'd0) begin
                        hold_in[0] = req_line_byte;
                     end else begin
                        hold_in[1] = req_line_byte;
                     end
                     hold_cnt_in = hold_cnt_ff + 2'd1;
                  end
               end else begin
                  // Queue the final bytes in order; the dropped end of line
                  // sits past the kept count.
                  unique case (hold_cnt_ff)
                     2'd0: hold_in[0] = req_line_byte;
                     2'd1: hold_in[1] = req_line_byte;
                     default: hold_in[2] = req_line_byte;
                  endcase
                  hold_cnt_in = lt_keep;
                  eol_bad_in  = lt_eol_bad;
                  if (lt_too_long) begin
                     err5_in = 1'b1;
                  end
                  phase_in = (lt_keep != 2'd0) ? PH_DRAIN : PH_CLOSE;
               end
            end
         end
         PH_DRAIN: begin
            if (room) begin
               feed_en     = 1'b1;
               hold_in[0]  = hold_ff[1];
               hold_in[1]  = hold_ff[2];
               hold_cnt_in = hold_cnt_ff - 2'd1;
               if (hold_cnt_ff == 2'd1) begin
                  phase_in = PH_CLOSE;
               end
            end
         end
         PH_CLOSE: begin
            if (room) begin
               if ((mode_ff == MODE_PLAIN) || (mode_ff == MODE_QUOTED)) begin
                  close_emit  = 1'b1;
                  unclosed_in = (mode_ff == MODE_QUOTED);
                  phase_in    = PH_STATUS;
               end else begin
                  status_push = 1'b1;
               end
            end
         end
         PH_STATUS: begin
            if (room) begin
               status_push = 1'b1;
            end
         end
         default: begin
            phase_in = PH_STREAM;
         end
      endcase

      if (feed_en) begin
         mode_in   = fd_mode_next;
         pos_in    = fd_pos_next;
         fstart_in = bs_start;
         na_ok_in  = nf_ok;
         na_len_in = nf_len;
         first_in  = nf_first;
         last_in   = nf_last;
         if (fd_over) begin
            err5_in = 1'b1;
         end
      end

      if ((feed_en && fd_emit) || close_emit) begin
         col_in = col_next;
         if (em_in_range) begin
            push_valid = 1'b1;
            if (em_bad) begin
               err4_in = 1'b1;
            end
         end
      end

      // The status transfer closes the line and restores the line state.
      if (status_push) begin
         push_valid  = 1'b1;
         push_item   = status_item;
         phase_in    = PH_STREAM;
         mode_in     = MODE_START;
         pos_in      = '0;
         hold_cnt_in = 2'd0;
         col_in      = '0;
         na_ok_in    = 1'b1;
         na_len_in   = '0;
         err5_in     = 1'b0;
         err4_in     = 1'b0;
         eol_bad_in  = 1'b0;
         unclosed_in = 1'b0;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_sep_ff       <= 8'd44;
         quote_byte_ff      <= 8'd34;
         eol_mode_ff        <= 1'b0;
         expected_fields_ff <= COL_W'(1);
         na_length_ff       <= '0;
         na_bytes_ff        <= '0;
         quoted_columns_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIELD_SEP:       field_sep_ff       <= csr_wdata[7:0];
            CSR_QUOTE_BYTE:      quote_byte_ff      <= csr_wdata[7:0];
            CSR_EOL_MODE:        eol_mode_ff        <= csr_wdata[0];
            CSR_EXPECTED_FIELDS: expected_fields_ff <= csr_wdata[COL_W-1:0];
            CSR_NA_LENGTH:       na_length_ff       <= csr_wdata[NA_LEN_W-1:0];
            CSR_NA_BYTES:        na_bytes_ff        <= csr_wdata;
            CSR_QUOTED_COLUMNS:  quoted_columns_ff  <= csr_wdata[QCOL_N-1:0];
            default: begin
            end
         endcase
      end
   end

   // Line control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_STREAM;
         mode_ff     <= MODE_START;
         pos_ff      <= '0;
         hold_cnt_ff <= 2'd0;
         col_ff      <= '0;
         na_ok_ff    <= 1'b1;
         na_len_ff   <= '0;
         err5_ff     <= 1'b0;
         err4_ff     <= 1'b0;
         eol_bad_ff  <= 1'b0;
         unclosed_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         hold_cnt_ff <= hold_cnt_in;
         col_ff      <= col_in;
         na_ok_ff    <= na_ok_in;
         na_len_ff   <= na_len_in;
         err5_ff     <= err5_in;
         err4_ff     <= err4_in;
         eol_bad_ff  <= eol_bad_in;
         unclosed_ff <= unclosed_in;
      end
   end

   // Held bytes and field bounds; these are only read while the control
   // state marks them as filled.
   always_ff @(posedge clock) begin
      hold_ff[0] <= hold_in[0];
      hold_ff[1] <= hold_in[1];
      hold_ff[2] <= hold_in[2];
      fstart_ff  <= fstart_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
   end

   csvfs_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .has_room   (room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (out_item)
   );

   assign rsp_item_kind     = out_item.kind;
   assign rsp_column_index  = out_item.column;
   assign rsp_field_start   = out_item.start;
   assign rsp_field_end     = out_item.stop;
   assign rsp_field_missing = out_item.missing;
   assign rsp_line_valid    = out_item.valid;
   assign rsp_error_code    = out_item.err;
   assign rsp_result_last   = out_item.last;

endmodule

// ----- sv/csvfs_checker.sv -----
module csvfs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_line_last,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_item_kind,
   input logic [csvfs_pkg::COL_W-1:0]      rsp_column_index,
   input logic [csvfs_pkg::POS_W-1:0]      rsp_field_start,
   input logic [csvfs_pkg::POS_W-1:0]      rsp_field_end,
   input logic                             rsp_field_missing,
   input logic                             rsp_line_valid,
   input logic [2:0]                       rsp_error_code,
   input logic                             rsp_result_last
);
   import csvfs_pkg::*;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_kind) &&
      $stable(rsp_column_index) && $stable(rsp_field_start) &&
      $stable(rsp_field_end) && $stable(rsp_error_code) && $stable(rsp_result_last))
      else $error("result changed while stalled");

   // A status result is the last of its line and carries no range start.
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind |-> rsp_result_last && !rsp_field_missing &&
      (rsp_field_start == '0) && (rsp_line_valid == (rsp_error_code == ERR_NONE)))
      else $error("malformed status result");

   // A field result only ever flags a badly quoted field and has an ordered range.
   a_field_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_kind |-> !rsp_result_last && !rsp_line_valid &&
      ((rsp_error_code == ERR_NONE) || (rsp_error_code == ERR_BAD_QUOTE)) &&
      (rsp_field_start <= rsp_field_end))
      else $error("malformed field result");

   // Once the final byte of a line is taken, req_ready is low in the next cycle.
   a_line_end_pause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_line_last |=> !req_ready)
      else $error("byte taken during line close");

   // Field results are only given for columns below the field limit.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_kind |-> ({1'b0, rsp_column_index} < MAX_FIELDS_C))
      else $error("field result beyond the field limit");

endmodule

bind csv_record_field_splitter_unit csvfs_checker u_csvfs_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the CSV record field splitter.
// Record lines stream in one byte per transfer. A byte-level model of the
// splitter runs alongside the block: every byte transfer on the req side is
// fed to it, and the field and status results it produces are queued. Every
// result transfer on the rsp side is compared field by field with the oldest
// queued result.
module testbench;
   import csvfs_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = 12;
   localparam int RESULTS_PER_BYTE = 4;
   localparam int PHASE_BYTES      = 24;
   localparam int RANDOM_PHASES    = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } line_xfer_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_line_byte = 8'h00;
   logic                  req_line_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_item_kind;
   logic [COL_W-1:0]      rsp_column_index;
   logic [POS_W-1:0]      rsp_field_start;
   logic [POS_W-1:0]      rsp_field_end;
   logic                  rsp_field_missing;
   logic                  rsp_line_valid;
   logic [2:0]            rsp_error_code;
   logic                  rsp_result_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   csv_record_field_splitter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_line_byte     (req_line_byte),
      .req_line_last     (req_line_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_column_index  (rsp_column_index),
      .rsp_field_start   (rsp_field_start),
      .rsp_field_end     (rsp_field_end),
      .rsp_field_missing (rsp_field_missing),
      .rsp_line_valid    (rsp_line_valid),
      .rsp_error_code    (rsp_error_code),
      .rsp_result_last   (rsp_result_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Bytes waiting to be sent, results waiting to arrive, and the line that
   // the stimulus code is currently putting together.
   line_xfer_type line_bytes_q[$];
   rsp_item_type  splits_due[$];
   logic [7:0]    line_buf[$];

   int   mismatches = 0;
   int   cycle_count = 0;
   int   phase_bytes = 0;
   logic no_gaps = 1'b0;

   // Register copies, kept in step with every csr transfer.
   logic [7:0]  cfg_sep;
   logic [7:0]  cfg_quote;
   logic        cfg_dos;
   logic [5:0]  cfg_fields;
   logic [3:0]  cfg_na_len;
   logic [63:0] cfg_na_str;
   logic [31:0] cfg_quoted;

   // Line scan state of the model.
   scan_mode_type scan;
   int            line_pos;
   logic [7:0]    hold_byte [2];
   int            hold_n;
   int            col_count;
   int            fld_start;
   logic          na_hit;
   int            na_seen;
   logic [7:0]    fld_first;
   logic [7:0]    fld_final;
   logic [2:0]    line_err;
   int            step_results;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < 40) begin
         $display("cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
      end
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Model of the splitter.
   // ---------------------------------------------------------------------

   function automatic int na_eff();
      return (cfg_na_len > NA_MAX_BYTES) ? NA_MAX_BYTES : int'(cfg_na_len);
   endfunction

   // Too long always wins; any other error only sticks if none is set yet.
   function automatic void flag_error(logic [2:0] code);
      if (code == ERR_TOO_LONG) begin
         line_err = ERR_TOO_LONG;
      end else if (line_err == ERR_NONE) begin
         line_err = code;
      end
   endfunction

   // A byte can give at most four results; anything past that is lost.
   function automatic void push_result(logic kind, int column, int start, int stop,
                                       logic missing, logic valid, logic [2:0] err,
                                       logic last);
      rsp_item_type r;
      if (step_results >= RESULTS_PER_BYTE) begin
         return;
      end
      r.kind    = kind;
      r.column  = COL_W'(column);
      r.start   = POS_W'(start);
      r.stop    = POS_W'(stop);
      r.missing = missing;
      r.valid   = valid;
      r.err     = err;
      r.last    = last;
      splits_due.insert(splits_due.size(), r);
      step_results++;
   endfunction

   function automatic void line_reset();
      scan         = MODE_START;
      line_pos     = 0;
      hold_byte[0] = 8'h00;
      hold_byte[1] = 8'h00;
      hold_n       = 0;
      col_count    = 0;
      fld_start    = 0;
      na_hit       = 1'b1;
      na_seen      = 0;
      fld_first    = 8'h00;
      fld_final    = 8'h00;
      line_err     = ERR_NONE;
   endfunction

   // Adds one byte to the open field: tracks its first and last byte and
   // whether it still matches the missing value string.
   function automatic void absorb_char(logic [7:0] c);
      if (na_seen == 0) begin
         fld_first = c;
      end
      fld_final = c;
      if (!(na_seen < na_eff() && c == 8'(cfg_na_str >> (8 * na_seen)))) begin
         na_hit = 1'b0;
      end
      if (na_seen <= NA_MAX_BYTES) begin
         na_seen++;
      end
   endfunction

   function automatic void close_field(int stop_pos);
      int         s;
      int         e;
      logic       miss;
      logic [2:0] err;
      if (col_count < MAX_FIELDS && col_count < COUNT_SAT) begin
         s    = fld_start;
         e    = stop_pos;
         err  = ERR_NONE;
         miss = na_hit && (na_seen == na_eff());
         // A quoted column must carry its quotes unless it is the missing string.
         if (!miss && col_count < QCOL_N && cfg_quoted[col_count]) begin
            if (na_seen >= 2 && fld_first == cfg_quote && fld_final == cfg_quote
                && e >= s + 2) begin
               s++;
               e--;
            end else begin
               err = ERR_BAD_QUOTE;
               flag_error(ERR_BAD_QUOTE);
            end
         end
         push_result(1'b0, col_count, s, e, miss, 1'b0, err, 1'b0);
      end
      if (col_count < COUNT_SAT) begin
         col_count++;
      end
   endfunction

   // One byte through the field scanner, after end of line stripping.
   function automatic void split_byte(logic [7:0] c);
      int p;
      int past_quote;
      p = line_pos;
      if (p >= LINE_LEN_MAX) begin
         flag_error(ERR_TOO_LONG);
         p = LINE_LEN_MAX;
      end else begin
         line_pos = p + 1;
      end
      past_quote = (p + 1 > LINE_LEN_MAX) ? LINE_LEN_MAX : p + 1;
      case (scan)
         MODE_START: begin
            fld_start = p;
            na_hit    = 1'b1;
            na_seen   = 0;
            fld_first = 8'h00;
            fld_final = 8'h00;
            if (cfg_quote != 8'h00 && c == cfg_quote) begin
               absorb_char(c);
               scan = MODE_QUOTED;
            end else if (c == cfg_sep) begin
               close_field(p);
            end else begin
               absorb_char(c);
               scan = MODE_PLAIN;
            end
         end
         MODE_PLAIN: begin
            if (c == cfg_sep) begin
               close_field(p);
               scan = MODE_START;
            end else begin
               absorb_char(c);
            end
         end
         MODE_QUOTED: begin
            absorb_char(c);
            if (c == cfg_quote) begin
               close_field(past_quote);
               scan = MODE_SKIP;
            end
         end
         default: begin
            // The byte right after a closing quote is dropped.
            scan = MODE_START;
         end
      endcase
   endfunction

   // Everything the block does for one byte transfer.
   function automatic void parse_byte(logic [7:0] c, logic last);
      logic [7:0] seq [3];
      int         n;
      int         keep;
      int         cnt;
      logic       eol_bad;
      logic       unclosed;
      logic       mismatch;
      logic [2:0] err;
      step_results = 0;
      if (!last) begin
         // Two bytes are always held back for end of line stripping.
         if (hold_n >= 2) begin
            split_byte(hold_byte[0]);
            hold_byte[0] = hold_byte[1];
            hold_n = 1;
         end
         hold_byte[hold_n] = c;
         hold_n++;
         return;
      end
      n = 0;
      for (int i = 0; i < hold_n; i++) begin
         seq[n] = hold_byte[i];
         n++;
      end
      seq[n] = c;
      n++;
      if (line_pos + n > LINE_LEN_MAX) begin
         flag_error(ERR_TOO_LONG);
      end
      keep    = n;
      eol_bad = 1'b0;
      if (c == CHAR_LF) begin
         if (!cfg_dos) begin
            keep = n - 1;
         end else if (n >= 2 && seq[n - 2] == CHAR_CR) begin
            keep = n - 2;
         end else begin
            eol_bad = 1'b1;
         end
      end
      for (int i = 0; i < keep; i++) begin
         split_byte(seq[i]);
      end
      unclosed = 1'b0;
      if (scan == MODE_PLAIN) begin
         close_field(line_pos);
      end else if (scan == MODE_QUOTED) begin
         close_field(line_pos);
         unclosed = 1'b1;
      end
      cnt      = col_count;
      mismatch = (cnt != cfg_fields) || (cnt > MAX_FIELDS) || (cnt >= COUNT_SAT);
      if (line_err == ERR_TOO_LONG) begin
         err = ERR_TOO_LONG;
      end else if (eol_bad) begin
         err = ERR_DOS_CR;
      end else if (unclosed) begin
         err = ERR_UNCLOSED;
      end else if (mismatch) begin
         err = ERR_COUNT;
      end else begin
         err = line_err;
      end
      push_result(1'b1, cnt, 0, line_pos, 1'b0, err == ERR_NONE, err, 1'b1);
      line_reset();
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one byte transfer at a time from line_bytes_q. Each accepted
   // byte goes straight into the model, so the expected results are queued
   // before the block can return them.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_line_byte, req_line_last);
         end
         // A new byte is offered only once the previous one has been taken.
         if (!req_valid || req_ready) begin
            if (line_bytes_q.size() != 0 && (no_gaps || $urandom_range(99) >= 33)) begin
               req_valid     <= 1'b1;
               req_line_byte <= line_bytes_q[0].data;
               req_line_last <= line_bytes_q[0].is_last;
               void'(line_bytes_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each result transfer against the oldest expected one
   // and stalls the result channel at random.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (splits_due.size() == 0) begin
               report_mismatch("unexpected result, column_index", rsp_column_index, 0);
            end else begin
               want = splits_due.pop_front();
               if (rsp_item_kind !== want.kind)
                  report_mismatch("item_kind", rsp_item_kind, want.kind);
               if (rsp_column_index !== want.column)
                  report_mismatch("column_index", rsp_column_index, want.column);
               if (rsp_field_start !== want.start)
                  report_mismatch("field_start", rsp_field_start, want.start);
               if (rsp_field_end !== want.stop)
                  report_mismatch("field_end", rsp_field_end, want.stop);
               if (rsp_field_missing !== want.missing)
                  report_mismatch("field_missing", rsp_field_missing, want.missing);
               if (rsp_line_valid !== want.valid)
                  report_mismatch("line_valid", rsp_line_valid, want.valid);
               if (rsp_error_code !== want.err)
                  report_mismatch("error_code", rsp_error_code, want.err);
               if (rsp_result_last !== want.last)
                  report_mismatch("result_last", rsp_result_last, want.last);
            end
         end
         rsp_ready <= no_gaps || ($urandom_range(99) >= 33);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------

   // One register write on the csr channel; the copy follows on the transfer.
   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FIELD_SEP:       cfg_sep    = value[7:0];
         CSR_QUOTE_BYTE:      cfg_quote  = value[7:0];
         CSR_EOL_MODE:        cfg_dos    = value[0];
         CSR_EXPECTED_FIELDS: cfg_fields = value[5:0];
         CSR_NA_LENGTH:       cfg_na_len = value[3:0];
         CSR_NA_BYTES:        cfg_na_str = value;
         CSR_QUOTED_COLUMNS:  cfg_quoted = value[31:0];
         default: ;
      endcase
   endtask

   // Waits until every byte is taken and every result is back, then lets the
   // block settle before the registers are touched again.
   task automatic wait_idle();
      while (line_bytes_q.size() != 0 || req_valid || splits_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Appends one byte to the line being assembled.
   function automatic void add_byte(logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endfunction

   // Moves the assembled line into the send queue, flagging its final byte.
   function automatic void queue_line();
      line_xfer_type x;
      if (line_buf.size() == 0) begin
         add_byte(CHAR_LF);
      end
      foreach (line_buf[i]) begin
         x.data    = line_buf[i];
         x.is_last = (i == line_buf.size() - 1);
         line_bytes_q.insert(line_bytes_q.size(), x);
      end
      phase_bytes += line_buf.size();
      line_buf.delete();
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endfunction

   // Field content: mostly lowercase letters, now and then any byte, never the
   // separator, the quote or an end of line byte.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(9) == 0) begin
            c = 8'($urandom);
         end else begin
            c = 8'($urandom_range(8'h7A, 8'h61));
         end
      end while (c == cfg_sep || c == cfg_quote || c == CHAR_LF || c == CHAR_CR);
      return c;
   endfunction

   // A record under the current settings. A careful record has the expected
   // field count, quotes its quoted columns and ends the line properly; a
   // careless one gets the count, the quoting and the line end wrong at random.
   function automatic void build_record(logic careful);
      int nf;
      int len;
      int pick;
      logic must_quote;
      nf = careful ? int'(cfg_fields) : $urandom_range(cfg_fields + 2);
      for (int i = 0; i < nf; i++) begin
         if (i > 0) begin
            add_byte(cfg_sep);
         end
         pick       = $urandom_range(9);
         must_quote = careful && i < QCOL_N && cfg_quoted[i];
         if (pick == 0 && cfg_na_len != 0) begin
            for (int k = 0; k < na_eff(); k++) begin
               add_byte(8'(cfg_na_str >> (8 * k)));
            end
         end else if (pick == 1 && !must_quote && !(careful && i == nf - 1)) begin
            // Empty field.
         end else if (cfg_quote != 8'h00 && (must_quote || pick <= 3)) begin
            // Quoted content may hold separators. The separator after the
            // closing quote is the skipped byte.
            add_byte(cfg_quote);
            len = $urandom_range(4);
            for (int k = 0; k < len; k++) begin
               add_byte(($urandom_range(4) == 0) ? cfg_sep : plain_char());
            end
            add_byte(cfg_quote);
         end else begin
            len = $urandom_range(5, 1);
            for (int k = 0; k < len; k++) begin
               add_byte(plain_char());
            end
         end
      end
      if (careful) begin
         if ($urandom_range(5) != 0) begin
            if (cfg_dos) begin
               add_byte(CHAR_CR);
            end
            add_byte(CHAR_LF);
         end
      end else begin
         case ($urandom_range(4))
            0: add_byte(CHAR_LF);
            1: begin
               add_byte(CHAR_CR);
               add_byte(CHAR_LF);
            end
            2: add_byte(CHAR_CR);
            3: begin
               // Leaves a quote open at the end of the line.
               add_byte(cfg_quote);
               add_byte(plain_char());
            end
            default: ;
         endcase
      end
   endfunction

   // Short bursts rich in separators, quotes and end of line bytes.
   function automatic void build_noise();
      int len;
      len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(4))
            0: add_byte(cfg_sep);
            1: add_byte(cfg_quote);
            2: add_byte(CHAR_CR);
            3: add_byte(CHAR_LF);
            default: add_byte(8'($urandom));
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [7:0]  sep_v;
      logic [7:0]  quote_v;
      logic [63:0] na_v;
      logic [31:0] qcol_v;
      logic [5:0]  fields_v;
      logic [3:0]  na_len_v;
      logic        dos_v;
      int          pick;

      // Register values after reset.
      cfg_sep    = 8'd44;
      cfg_quote  = 8'd34;
      cfg_dos    = 1'b0;
      cfg_fields = 6'd1;
      cfg_na_len = 4'd0;
      cfg_na_str = 64'd0;
      cfg_quoted = 32'd0;
      line_reset();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed lines with the reset settings: an empty Unix line, the
      // smallest and largest byte values, an unclosed quote, a trailing empty
      // field after a separator, and a byte skipped after a closing quote.
      add_byte(CHAR_LF);
      queue_line();
      add_byte(8'h00);
      add_byte(8'hFF);
      queue_line();
      add_text("\"a");
      queue_line();
      add_text("a,");
      queue_line();
      add_text("\"x\"y");
      queue_line();
      wait_idle();

      // Directed lines in DOS mode with two quoted columns and a two byte
      // missing string: a newline without carriage return, an empty line, a
      // missing field followed by a properly quoted one, and a line with a
      // badly quoted field and an unclosed quote where the latter wins.
      write_reg(CSR_EOL_MODE, 64'd1);
      write_reg(CSR_QUOTED_COLUMNS, 64'd3);
      write_reg(CSR_NA_LENGTH, 64'd2);
      write_reg(CSR_NA_BYTES, 64'h414E);
      write_reg(CSR_EXPECTED_FIELDS, 64'd2);
      add_text("a");
      add_byte(CHAR_LF);
      queue_line();
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
      queue_line();
      add_text("NA,\"q\"");
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
      queue_line();
      add_text("b,\"");
      add_byte(CHAR_CR);
      add_byte(CHAR_LF);
      queue_line();
      wait_idle();

      // Random phases. The first two use the extreme settings; the rest draw
      // theirs at random. All registers are written in every phase.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            sep_v    = 8'h00;
            quote_v  = 8'hFF;
            dos_v    = 1'b1;
            fields_v = 6'd32;
            na_len_v = 4'd8;
            qcol_v   = 32'hFFFF_FFFF;
         end else if (phase == 1) begin
            sep_v    = 8'hFF;
            quote_v  = 8'h00;
            dos_v    = 1'b0;
            fields_v = 6'd0;
            na_len_v = 4'd0;
            qcol_v   = 32'd0;
         end else begin
            case ($urandom_range(5))
               0: sep_v = ",";
               1: sep_v = ";";
               2: sep_v = 8'h09;
               3: sep_v = "|";
               default: sep_v = 8'($urandom);
            endcase
            case ($urandom_range(4))
               0, 1: quote_v = 8'h22;
               2: quote_v = 8'h27;
               3: quote_v = 8'h00;
               default: quote_v = 8'($urandom);
            endcase
            dos_v    = 1'($urandom_range(1));
            fields_v = ($urandom_range(3) != 0) ? 6'($urandom_range(5, 1))
                                                : 6'($urandom_range(32));
            // Lengths beyond eight are taken as eight.
            na_len_v = ($urandom_range(5) == 0) ? 4'd15 : 4'($urandom_range(4));
            case ($urandom_range(3))
               0: qcol_v = 32'd0;
               1: qcol_v = $urandom;
               2: qcol_v = 32'($urandom_range(15));
               default: qcol_v = 32'hFFFF_FFFF;
            endcase
         end
         // Separator and quote go first: the missing string is drawn from
         // content bytes under the new settings.
         write_reg(CSR_FIELD_SEP, 64'(sep_v));
         write_reg(CSR_QUOTE_BYTE, 64'(quote_v));
         if (phase == 0) begin
            na_v = 64'hFFFF_FFFF_FFFF_FFFF;
         end else begin
            for (int k = 0; k < 8; k++) begin
               na_v[8 * k +: 8] = plain_char();
            end
         end
         write_reg(CSR_EOL_MODE, 64'(dos_v));
         write_reg(CSR_EXPECTED_FIELDS, 64'(fields_v));
         write_reg(CSR_NA_LENGTH, 64'(na_len_v));
         write_reg(CSR_NA_BYTES, na_v);
         write_reg(CSR_QUOTED_COLUMNS, 64'(qcol_v));

         // One phase runs with both channels fully busy.
         no_gaps     = (phase == 3);
         phase_bytes = 0;

         if (phase == 2) begin
            // More separators than columns can be reported: the field results
            // stop at the column limit and the count saturates.
            for (int k = 0; k < 70; k++) begin
               add_byte(cfg_sep);
            end
            add_byte(CHAR_LF);
            queue_line();
         end

         while (phase_bytes < PHASE_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               build_record(1'b1);
            end else if (pick < 88) begin
               build_record(1'b0);
            end else begin
               build_noise();
            end
            queue_line();
         end
         wait_idle();
      end
      no_gaps = 1'b0;

      if (splits_due.size() != 0) begin
         report_mismatch("results never returned", 0, splits_due.size());
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
